// ----- design/gpef_pkg.sv -----
// ----------------------------------------------------------------------------
// gpef_pkg: shared types and constants of the gray Prewitt edge filter
// Holds grey conversion weights, field widths, register map and the clamp.
// ----------------------------------------------------------------------------
package gpef_pkg;

	// BT.709 luma weights in 16-bit fixed point (sum is 65536)
	localparam logic [15:0] W_RED   = 16'd13933;
	localparam logic [15:0] W_GREEN = 16'd46871;
	localparam logic [15:0] W_BLUE  = 16'd4732;

	localparam int DEF_MAX_WIDTH = 1024;

	localparam int WIDTH_W  = 11;
	localparam int HEIGHT_W = 13;
	localparam int ROW_W    = HEIGHT_W + 1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

	// register indexes (byte address 4*index)
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// request kinds carried on the input tuser
	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_DRAIN = 1'b1;

	// depth of the result queue ahead of the output port
	localparam int OUT_DEPTH = 4;

	typedef logic [7:0] pix_t;

	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	typedef struct packed {
		logic valid;
		logic col0;
	} kern_ctl_t;

	function automatic pix_t clamp_u8(input logic signed [10:0] v);
		pix_t res;
		if (v < 0) begin
			res = 8'd0;
		end else if (v > 11'sd255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

endpackage

// ----- design/gpef_ram.sv -----
// ----------------------------------------------------------------------------
// gpef_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module gpef_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- design/gpef_kernel.sv -----
// ----------------------------------------------------------------------------
// gpef_kernel: 3x3 window and Prewitt responses
// Holds the left and centre columns; the right column is the fresh one.
// ----------------------------------------------------------------------------
module gpef_kernel
	import gpef_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  kern_ctl_t ctl,
	input  col_t      fresh,
	output pix_t      edge_h,
	output pix_t      edge_v
);

	col_t left_q;
	col_t mid_q;
	col_t right_col;
	logic [9:0] sum_l;
	logic [9:0] sum_r;
	logic [9:0] sum_top;
	logic [9:0] sum_bot;

	// at the start of a line the right column lies outside the image
	assign right_col = ctl.col0 ? '0 : fresh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			mid_q  <= '0;
		end else if (ctl.valid) begin
			left_q <= ctl.col0 ? '0 : mid_q;
			mid_q  <= fresh;
		end
	end

	always_comb begin
		sum_l   = 10'(left_q.top) + 10'(left_q.mid) + 10'(left_q.bot);
		sum_r   = 10'(right_col.top) + 10'(right_col.mid) + 10'(right_col.bot);
		sum_top = 10'(left_q.top) + 10'(mid_q.top) + 10'(right_col.top);
		sum_bot = 10'(left_q.bot) + 10'(mid_q.bot) + 10'(right_col.bot);
		edge_h  = clamp_u8($signed({1'b0, sum_r}) - $signed({1'b0, sum_l}));
		edge_v  = clamp_u8($signed({1'b0, sum_bot}) - $signed({1'b0, sum_top}));
	end

endmodule

// ----- design/gray_prewitt_edge_filter.sv -----
// ----------------------------------------------------------------------------
// gray_prewitt_edge_filter: RGB to grey, then 3x3 Prewitt edge responses
// Top level: stream ports, APB register port, line RAM and result queue.
// ----------------------------------------------------------------------------
// Feed RGB pixels in raster order, one transaction per pixel with tuser low.
// Each pixel becomes grey with BT.709 weights (truncated), and horizontal and
// vertical Prewitt responses with zero padding are returned clamped to 0..255.
// The block takes one transaction per clock and keeps that rate indefinitely
// while the output side keeps up; behind combinational position counters it
// is a two-stage pipeline (grey conversion with line RAM read, then window and
// kernel) followed by a four-entry result queue; a result passes through both
// stages and the queue before it is offered. The input stalls once queued
// and in-flight results reach four. The result for pixel (y,x)
// is caused by the transaction image_width+1 positions later, so the first
// image_width+1 pixels of a frame give no result. After the last pixel of a
// frame, send image_width+1 drain transactions (tuser high); the last of them
// returns the frame's final result with tlast set. A drain transaction
// outside a drain is dropped; a pixel during a drain abandons it and starts a
// new frame. Both line stores share one RAM that needs no clearing after
// reset: entries are always written within a frame before they are read.
// image_width is used as clamp(value,1,MAX_WIDTH), image_height 0 as 1.
// Writing either register restarts the frame; write only while idle.
// ----------------------------------------------------------------------------
module gray_prewitt_edge_filter
	import gpef_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// pixel stream in
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
	input  logic        s_axis_tuser,  // req_type: 0 pixel, 1 drain
	// edge stream out
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // edge_horizontal [7:0], edge_vertical [15:8]
	output logic        m_axis_tlast,  // last_of_frame
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int QW = $clog2(OUT_DEPTH);
	localparam int NW = $clog2(OUT_DEPTH + 1);

	// ---------------------------------------------------------------- registers
	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RST;
			image_height_q <= HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_WIDTH:  image_width_q  <= pwdata[WIDTH_W-1:0];
				REG_HEIGHT: image_height_q <= pwdata[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = 32'(image_width_q);
			REG_HEIGHT: prdata = 32'(image_height_q);
			default:    prdata = '0;
		endcase
	end

	// effective geometry
	logic [WW-1:0]       w_eff;
	logic [HEIGHT_W-1:0] h_eff;

	always_comb begin
		if (image_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width_q);
		end
		h_eff = (image_height_q == '0) ? HEIGHT_W'(1) : image_height_q;
	end

	// ---------------------------------------------------- position counters
	logic [CW-1:0]    col_q;
	logic [ROW_W-1:0] row_q;
	logic [PW-1:0]    pend_q;

	logic             fire;
	logic             is_pix;
	logic             restart;
	logic             active;
	logic [CW-1:0]    c_use;
	logic [ROW_W-1:0] r_use;
	logic [CW:0]      c_plus;
	logic             wrap;
	logic [CW-1:0]    col_adv;
	logic [ROW_W-1:0] row_adv;
	logic [PW-1:0]    pend_dec;
	logic [CW-1:0]    col_nxt;
	logic [ROW_W-1:0] row_nxt;
	logic [PW-1:0]    pend_nxt;
	logic             emit;
	logic             last;

	assign fire = s_axis_tvalid & s_axis_tready;

	always_comb begin
		is_pix   = (s_axis_tuser == REQ_PIXEL);
		restart  = is_pix && (pend_q != '0 || row_q >= ROW_W'(h_eff));
		active   = is_pix || (pend_q != '0);
		c_use    = restart ? '0 : col_q;
		r_use    = restart ? '0 : row_q;
		emit     = (r_use >= ROW_W'(2)) || (r_use == ROW_W'(1) && c_use != '0);
		c_plus   = (CW+1)'(c_use) + (CW+1)'(1);
		wrap     = 32'(c_plus) >= 32'(w_eff);
		col_adv  = wrap ? '0 : c_plus[CW-1:0];
		row_adv  = wrap ? r_use + ROW_W'(1) : r_use;
		pend_dec = pend_q - PW'(1);
		last     = 1'b0;
		if (is_pix) begin
			col_nxt  = col_adv;
			row_nxt  = row_adv;
			pend_nxt = (wrap && row_adv >= ROW_W'(h_eff)) ? PW'(w_eff) + PW'(1) : '0;
		end else if (pend_q != '0) begin
			// drain: on the final tick close the frame
			if (pend_dec == '0) begin
				col_nxt  = '0;
				row_nxt  = '0;
				pend_nxt = '0;
				last     = 1'b1;
			end else begin
				col_nxt  = col_adv;
				row_nxt  = row_adv;
				pend_nxt = pend_dec;
			end
		end else begin
			col_nxt  = col_q;
			row_nxt  = row_q;
			pend_nxt = pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (cfg_wr) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (fire) begin
			col_q  <= col_nxt;
			row_q  <= row_nxt;
			pend_q <= pend_nxt;
		end
	end

	// ---------------------------------------------------------- stage 1
	logic          valid_s1, pix_s1, col0_s1, rge1_s1, rge2_s1, emit_s1, last_s1;
	logic [CW-1:0] addr_s1;
	pix_t          red_s1, green_s1, blue_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
		end else begin
			valid_s1 <= fire & active;
			emit_s1  <= fire & active & emit;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1   <= is_pix;
		col0_s1  <= (c_use == '0);
		rge1_s1  <= (r_use >= ROW_W'(1));
		rge2_s1  <= (r_use >= ROW_W'(2));
		last_s1  <= last;
		addr_s1  <= c_use;
		red_s1   <= s_axis_tdata[7:0];
		green_s1 <= s_axis_tdata[15:8];
		blue_s1  <= s_axis_tdata[23:16];
	end

	// grey conversion: weights sum to 65536, so the top byte is the result
	logic [23:0] luma_sum;

	assign luma_sum = {8'd0, W_RED} * {16'd0, red_s1}
		+ {8'd0, W_GREEN} * {16'd0, green_s1}
		+ {8'd0, W_BLUE} * {16'd0, blue_s1};

	// ---------------------------------------------------------- stage 2
	logic          valid_s2, pix_s2, col0_s2, rge1_s2, rge2_s2, emit_s2, last_s2;
	logic [CW-1:0] addr_s2;
	pix_t          gray_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			emit_s2  <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			emit_s2  <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s2  <= pix_s1;
		col0_s2 <= col0_s1;
		rge1_s2 <= rge1_s1;
		rge2_s2 <= rge2_s1;
		last_s2 <= last_s1;
		addr_s2 <= addr_s1;
		gray_s2 <= luma_sum[23:16];
	end

	// line RAM: upper line in the high byte, middle line in the low byte
	logic [15:0] ram_rdata;
	logic [15:0] line_word;
	logic [15:0] ram_wdata;
	logic        ram_we;
	logic        byp_q;
	logic [15:0] byp_word_q;

	assign ram_we    = valid_s2 & pix_s2;
	assign line_word = byp_q ? byp_word_q : ram_rdata;
	assign ram_wdata = {line_word[7:0], gray_s2};

	gpef_ram #(
		.WIDTH (16),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_s2),
		.wdata (ram_wdata),
		.re    (valid_s1),
		.raddr (addr_s1),
		.rdata (ram_rdata)
	);

	// forward a write that lands on the address being read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= valid_s1 & ram_we & (addr_s2 == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		byp_word_q <= ram_wdata;
	end

	col_t      fresh;
	kern_ctl_t kctl;
	pix_t      edge_h, edge_v;

	always_comb begin
		fresh.top  = rge2_s2 ? line_word[15:8] : 8'd0;
		fresh.mid  = rge1_s2 ? line_word[7:0] : 8'd0;
		fresh.bot  = pix_s2 ? gray_s2 : 8'd0;
		kctl.valid = valid_s2;
		kctl.col0  = col0_s2;
	end

	gpef_kernel u_kernel (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (kctl),
		.fresh  (fresh),
		.edge_h (edge_h),
		.edge_v (edge_v)
	);

	// ---------------------------------------------------------- result queue
	pix_t          qh_q [OUT_DEPTH];
	pix_t          qv_q [OUT_DEPTH];
	logic          ql_q [OUT_DEPTH];
	logic [QW-1:0] head_q, tail_q;
	logic [NW-1:0] cnt_q;
	logic          push, pop;

	assign push = emit_s2;
	assign pop  = m_axis_tvalid & m_axis_tready;

	// hold back input while queued plus in-flight results would fill the queue
	assign s_axis_tready = (4'(cnt_q) + 4'(emit_s1) + 4'(emit_s2)) < 4'(OUT_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				tail_q <= tail_q + QW'(1);
			end
			if (pop) begin
				head_q <= head_q + QW'(1);
			end
			cnt_q <= cnt_q + NW'(push) - NW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qh_q[tail_q] <= edge_h;
			qv_q[tail_q] <= edge_v;
			ql_q[tail_q] <= last_s2;
		end
	end

	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = {qv_q[head_q], qh_q[head_q]};
	assign m_axis_tlast  = ql_q[head_q];

endmodule

// ----- sim/tb_gray_prewitt_edge_filter.sv -----
// ----------------------------------------------------------------------------
// tb_gray_prewitt_edge_filter: self-checking regression of the edge filter
// Streams RGB pixels and drain transactions with random gaps and output
// stalls, predicts every grey Prewitt result in a scoreboard and compares
// each returned transaction field by field. Image size is reprogrammed over
// APB between phases, covering the width and height clamps.
// ----------------------------------------------------------------------------
module tb_gray_prewitt_edge_filter
	import gpef_pkg::*;
();

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int SETTLE       = 12;   // pipeline plus result queue, with margin
	localparam int LONG_HOLD    = 300;
	localparam int RANDOM_ITEMS = 200;
	localparam int MAX_REPORTS  = 100;
	localparam int LINE_MAX     = DEF_MAX_WIDTH;

	// luma weights, 16-bit fixed point
	localparam int unsigned LUMA_R = 13933;
	localparam int unsigned LUMA_G = 46871;
	localparam int unsigned LUMA_B = 4732;

	// which registers a reprogramming step touches
	localparam int unsigned WR_BOTH        = 0;
	localparam int unsigned WR_WIDTH_ONLY  = 1;
	localparam int unsigned WR_HEIGHT_ONLY = 2;

	typedef struct packed {
		pix_t horiz;
		pix_t vert;
		logic last;
	} edge_result_t;

	class edge_checker;
		pix_t                upper_line [LINE_MAX];
		pix_t                middle_line [LINE_MAX];
		col_t                win [3];   // left, middle, right column
		int unsigned         col_pos;
		int unsigned         row_pos;
		int unsigned         drain_left;
		logic [WIDTH_W-1:0]  width_reg;
		logic [HEIGHT_W-1:0] height_reg;
		edge_result_t        pending_edges [$];
		int unsigned         fail_count;

		function new();
			foreach (upper_line[i]) begin
				upper_line[i]  = 8'd0;
				middle_line[i] = 8'd0;
			end
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			fail_count = 0;
			restart_frame();
		endfunction

		function int unsigned line_width();
			if (width_reg == 0) return 1;
			if (width_reg > LINE_MAX) return LINE_MAX;
			return width_reg;
		endfunction

		function int unsigned frame_height();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function void restart_frame();
			win[0]     = '0;
			win[1]     = '0;
			win[2]     = '0;
			col_pos    = 0;
			row_pos    = 0;
			drain_left = 0;
		endfunction

		function pix_t sat8(int v);
			if (v < 0) return 8'd0;
			if (v > 255) return 8'd255;
			return pix_t'(v);
		endfunction

		function int col_total(col_t c);
			return int'(c.top) + int'(c.mid) + int'(c.bot);
		endfunction

		// Advance the window one position; returns 1 when a result is due.
		function bit slide_window(bit have_pix, pix_t gray, output pix_t horiz,
				output pix_t vert);
			int unsigned c;
			col_t fresh, l, m, r;
			bit due;
			c = col_pos % LINE_MAX;
			fresh.top = (row_pos >= 2) ? upper_line[c] : 8'd0;
			fresh.mid = (row_pos >= 1) ? middle_line[c] : 8'd0;
			fresh.bot = have_pix ? gray : 8'd0;
			if (have_pix) begin
				upper_line[c]  = middle_line[c];
				middle_line[c] = gray;
			end
			if (c == 0) begin
				// line start: finish the previous line against zero padding
				l      = win[1];
				m      = win[2];
				r      = '0;
				win[0] = '0;
				win[1] = '0;
			end else begin
				win[0] = win[1];
				win[1] = win[2];
				l      = win[0];
				m      = win[1];
				r      = fresh;
			end
			win[2] = fresh;
			horiz = sat8(col_total(r) - col_total(l));
			vert  = sat8((int'(l.bot) + int'(m.bot) + int'(r.bot))
				- (int'(l.top) + int'(m.top) + int'(r.top)));
			due = (row_pos >= 2) || (row_pos == 1 && c >= 1);
			col_pos = c + 1;
			if (col_pos >= line_width()) begin
				col_pos = 0;
				row_pos++;
			end
			return due;
		endfunction

		function void accept_input(logic req, pix_t red, pix_t green, pix_t blue);
			int unsigned sum;
			pix_t gray;
			edge_result_t res;
			bit due;
			res.last = 1'b0;
			if (req == REQ_PIXEL) begin
				sum  = LUMA_R * red + LUMA_G * green + LUMA_B * blue;
				gray = pix_t'(sum >> 16);
				// a pixel during a drain abandons it and opens a new frame
				if (drain_left != 0 || row_pos >= frame_height())
					restart_frame();
				due = slide_window(1'b1, gray, res.horiz, res.vert);
				if (row_pos >= frame_height() && col_pos == 0)
					drain_left = line_width() + 1;
				if (due)
					pending_edges.push_back(res);
			end else if (drain_left != 0) begin
				due = slide_window(1'b0, 8'd0, res.horiz, res.vert);
				drain_left--;
				if (drain_left == 0) begin
					restart_frame();
					res.last = 1'b1;
				end
				if (due)
					pending_edges.push_back(res);
			end
		endfunction

		function void write_reg(logic reg_sel, logic [31:0] data);
			if (reg_sel == REG_WIDTH)
				width_reg = data[WIDTH_W-1:0];
			else
				height_reg = data[HEIGHT_W-1:0];
			restart_frame();
		endfunction

		function void report(string what, int want, int got);
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
		endfunction

		function void compare_result(pix_t horiz, pix_t vert, logic last);
			edge_result_t want;
			if (pending_edges.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("%0t: unexpected result: expected none, actual %0d %0d %0b",
						$time, horiz, vert, last);
				return;
			end
			want = pending_edges.pop_front();
			if (want.horiz !== horiz) report("edge_horizontal", want.horiz, horiz);
			if (want.vert !== vert) report("edge_vertical", want.vert, vert);
			if (want.last !== last) report("last_of_frame", want.last, last);
		endfunction
	endclass

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        psel          = 1'b0;
	logic        penable       = 1'b0;
	logic        pwrite        = 1'b0;
	logic [2:0]  paddr         = '0;
	logic [31:0] pwdata        = '0;
	logic [31:0] prdata;
	logic        pready;

	edge_checker edges;
	bit          quiet_mode   = 1'b0;   // no gaps and no random stalls
	bit          hold_request = 1'b0;
	int unsigned stall_left   = 0;
	int unsigned stall_pick;
	int unsigned sent_items   = 0;

	gray_prewitt_edge_filter u_top (.*);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Output side: check each accepted transaction, then pick the next tready.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			edges.compare_result(m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tlast);
		if (hold_request) begin
			hold_request = 1'b0;
			stall_left   = LONG_HOLD;
		end else if (stall_left == 0 && !quiet_mode) begin
			stall_pick = $urandom_range(99);
			if (stall_pick < 10)
				stall_left = $urandom_range(3, 1);
			else if (stall_pick < 13)
				stall_left = $urandom_range(40, 8);
		end
		if (stall_left != 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 70) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic pix_t rand_pix();
		return pix_t'($urandom_range(255));
	endfunction

	// colour component biased towards the extremes
	function automatic pix_t rand_comp();
		if ($urandom_range(3) == 0)
			return $urandom_range(1) ? 8'd255 : 8'd0;
		return rand_pix();
	endfunction

	task automatic push_item(input logic req, input pix_t red, input pix_t green,
			input pix_t blue);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= req;
		s_axis_tdata  <= {blue, green, red};
		do @(posedge clk); while (!s_axis_tready);
		edges.accept_input(req, red, green, blue);
		sent_items++;
		gap = quiet_mode ? 0 : pick_gap();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(input int unsigned pixels, input int unsigned drains);
		repeat (pixels) push_item(REQ_PIXEL, rand_comp(), rand_comp(), rand_comp());
		repeat (drains) push_item(REQ_DRAIN, rand_pix(), rand_pix(), rand_pix());
	endtask

	// Hold the input until every expected result is back and the pipe is empty.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (edges.pending_edges.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic apb_write(input logic reg_sel, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		edges.write_reg(reg_sel, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Upper bits carry junk now and then; only the field bits count.
	task automatic write_regs(input int unsigned w_raw, input int unsigned h_raw,
			input int unsigned which);
		logic [31:0] data;
		if (which != WR_HEIGHT_ONLY) begin
			data = $urandom_range(1) ? $urandom : 32'd0;
			data[WIDTH_W-1:0] = w_raw[WIDTH_W-1:0];
			apb_write(REG_WIDTH, data);
		end
		if (which != WR_WIDTH_ONLY) begin
			data = $urandom_range(1) ? $urandom : 32'd0;
			data[HEIGHT_W-1:0] = h_raw[HEIGHT_W-1:0];
			apb_write(REG_HEIGHT, data);
		end
	endtask

	task automatic random_phase();
		int unsigned p, w_raw, h_raw, w, h, frames, kind, half;
		p = $urandom_range(99);
		if (p < 5)       w_raw = 0;
		else if (p < 30) w_raw = $urandom_range(3, 1);
		else if (p < 85) w_raw = $urandom_range(12, 4);
		else             w_raw = $urandom_range(40, 13);
		p = $urandom_range(99);
		if (p < 10)      h_raw = 0;
		else if (p < 90) h_raw = $urandom_range(4, 1);
		else             h_raw = $urandom_range(8, 5);
		write_regs(w_raw, h_raw, $urandom_range(2));
		w = edges.line_width();
		h = edges.frame_height();
		quiet_mode = ($urandom_range(4) == 0);
		frames = $urandom_range(3, 1);
		repeat (frames) begin
			kind = $urandom_range(9);
			unique case (kind)
				6: begin
					// cut the drain short; the next pixel or write drops it
					send_frame(w * h, $urandom_range(w, 0));
				end
				7: begin
					// drains with no drain in progress are dropped
					send_frame(0, $urandom_range(3, 1));
					send_frame(w * h, w + 1);
					send_frame(0, 1);
				end
				8: begin
					send_frame($urandom_range(w * h, 1), 0);
				end
				9: begin
					// sender pauses mid-frame until the output side catches up
					half = (w * h) / 2;
					send_frame(half, 0);
					settle();
					send_frame(w * h - half, w + 1);
				end
				default: begin
					send_frame(w * h, w + 1);
				end
			endcase
		end
		quiet_mode = 1'b0;
		settle();
	endtask

	initial begin
		int unsigned goal;
		int unsigned i;
		pix_t v;
		edges = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// drain straight after reset: nothing to flush, drop it
		push_item(REQ_DRAIN, rand_pix(), rand_pix(), rand_pix());
		settle();
		write_regs(3, 2, WR_BOTH);
		// checkerboard of white and black saturates both kernels
		for (i = 0; i < 6; i++) begin
			v = (i % 2 == 0) ? 8'd255 : 8'd0;
			push_item(REQ_PIXEL, v, v, v);
		end
		send_frame(0, 4);
		send_frame(0, 1);
		// primaries and odd values, then a drain abandoned by a pixel
		push_item(REQ_PIXEL, 8'd255, 8'd0, 8'd0);
		push_item(REQ_PIXEL, 8'd0, 8'd255, 8'd0);
		push_item(REQ_PIXEL, 8'd0, 8'd0, 8'd255);
		push_item(REQ_PIXEL, 8'd128, 8'd64, 8'd32);
		push_item(REQ_PIXEL, 8'd1, 8'd2, 8'd4);
		push_item(REQ_PIXEL, 8'd254, 8'd253, 8'd252);
		send_frame(0, 2);
		push_item(REQ_PIXEL, 8'd0, 8'd0, 8'd0);
		settle();
		// zero width and height act as one: single-pixel frame
		write_regs(0, 0, WR_BOTH);
		push_item(REQ_PIXEL, 8'd255, 8'd255, 8'd255);
		send_frame(0, 2);
		settle();

		// long output stall while the sender keeps offering at full rate
		write_regs(8, 6, WR_BOTH);
		quiet_mode   = 1'b1;
		hold_request = 1'b1;
		send_frame(48, 9);
		quiet_mode = 1'b0;
		settle();

		// widest line: full or clamped width, tallest height, one line plus a few pixels
		write_regs($urandom_range(1) ? 1024 : 2047, 8191, WR_BOTH);
		send_frame(LINE_MAX + 24, 0);
		settle();

		goal = sent_items + RANDOM_ITEMS;
		while (sent_items < goal)
			random_phase();

		settle();
		if (edges.fail_count == 0 && edges.pending_edges.size() == 0) begin
			$display("gray_prewitt_edge_filter regression: pass");
		end else begin
			$display("gray_prewitt_edge_filter regression: fail");
		end
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("gray_prewitt_edge_filter regression: fail");
		$finish;
	end

endmodule
